FILE: sv/gti_pkg.sv
// Shared types and codes of the grid trilinear interpolator.
package gti_pkg;

    // Kinds of queued words, decided by the front end.
    localparam logic [2:0] K_SPEED = 3'd0;
    localparam logic [2:0] K_LOAD  = 3'd1;
    localparam logic [2:0] K_SLOPE = 3'd2;
    localparam logic [2:0] K_TABLE = 3'd3;
    localparam logic [2:0] K_QUERY = 3'd4;
    localparam logic [2:0] K_ZERO  = 3'd5;

    // Input modes.
    localparam logic [2:0] M_SPEED = 3'd0;
    localparam logic [2:0] M_LOAD  = 3'd1;
    localparam logic [2:0] M_SLOPE = 3'd2;
    localparam logic [2:0] M_TABLE = 3'd3;
    localparam logic [2:0] M_QUERY = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] R_SPEED_POINTS = 2'd0;
    localparam logic [1:0] R_LOAD_POINTS  = 2'd1;
    localparam logic [1:0] R_SLOPE_POINTS = 2'd2;

    localparam int QDEPTH = 2;
    localparam logic [16:0] T_ONE = 17'h10000;

    typedef struct packed {
        logic [4:0] spd;
        logic [4:0] lod;
        logic [3:0] slp;
    } cnt_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         sel;
        logic [10:0]        idx;
        logic signed [31:0] value;
        logic signed [31:0] qv;
        logic signed [31:0] qg;
        logic signed [31:0] qs;
    } qword_t;

endpackage

FILE: sv/gti_if.sv
// Channel interfaces of the grid trilinear interpolator.
interface gti_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [1:0]         table_select;
    logic [10:0]        entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_speed;
    logic signed [31:0] query_load;
    logic signed [31:0] query_slope;

    modport source (output valid, mode, table_select, entry_index, entry_value,
                    query_speed, query_load, query_slope, input ready);
    modport sink (input valid, mode, table_select, entry_index, entry_value,
                  query_speed, query_load, query_slope, output ready);
endinterface

interface gti_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interpolated;

    modport source (output valid, interpolated, input ready);
    modport sink (input valid, interpolated, output ready);
endinterface

interface gti_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] addr;
    logic [4:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

FILE: sv/gti_front.sv
// Front end: configuration registers and classification of input words.
module gti_front #(
    parameter int SPEED_MAX   = 16,
    parameter int LOAD_MAX    = 16,
    parameter int SLOPE_MAX   = 8,
    parameter int TABLE_COUNT = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    gti_item_if.sink        item,
    gti_cfg_if.sink         cfg,
    output gti_pkg::cnt_t   cnt,
    output logic            push_valid,
    input  logic            push_ready,
    output gti_pkg::qword_t push_word
);
    import gti_pkg::*;

    logic [4:0] spd_reg;
    logic [4:0] lod_reg;
    logic [3:0] slp_reg;
    logic       keep;
    logic [2:0] kind;
    logic       sel_ok;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_reg <= 5'd2;
            lod_reg <= 5'd2;
            slp_reg <= 4'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                R_SPEED_POINTS: spd_reg <= cfg.data;
                R_LOAD_POINTS:  lod_reg <= cfg.data;
                R_SLOPE_POINTS: slp_reg <= cfg.data[3:0];
                default:        ;
            endcase
        end
    end

    // Counts saturate to the range each axis supports.
    always_comb
    begin
        if (spd_reg < 5'd2)
            cnt.spd = 5'd2;
        else if (int'(spd_reg) > SPEED_MAX)
            cnt.spd = 5'(SPEED_MAX);
        else
            cnt.spd = spd_reg;
        if (lod_reg < 5'd2)
            cnt.lod = 5'd2;
        else if (int'(lod_reg) > LOAD_MAX)
            cnt.lod = 5'(LOAD_MAX);
        else
            cnt.lod = lod_reg;
        if (int'(slp_reg) > SLOPE_MAX)
            cnt.slp = 4'(SLOPE_MAX);
        else
            cnt.slp = slp_reg;
    end

    // Words that change nothing are accepted and dropped here.
    always_comb
    begin
        sel_ok = int'(item.table_select) < TABLE_COUNT;
        keep = 1'b0;
        kind = K_ZERO;
        case (item.mode)
            M_SPEED:
            begin
                keep = int'(item.entry_index) < SPEED_MAX;
                kind = K_SPEED;
            end
            M_LOAD:
            begin
                keep = int'(item.entry_index) < LOAD_MAX;
                kind = K_LOAD;
            end
            M_SLOPE:
            begin
                keep = int'(item.entry_index) < SLOPE_MAX;
                kind = K_SLOPE;
            end
            M_TABLE:
            begin
                keep = sel_ok;
                kind = K_TABLE;
            end
            M_QUERY:
            begin
                keep = 1'b1;
                kind = sel_ok ? K_QUERY : K_ZERO;
            end
            default: keep = 1'b0;
        endcase
    end

    assign item.ready = push_ready;
    assign push_valid = item.valid && keep;
    assign push_word = '{kind: kind, sel: item.table_select, idx: item.entry_index,
                         value: item.entry_value, qv: item.query_speed,
                         qg: item.query_load, qs: item.query_slope};

endmodule

FILE: sv/gti_queue.sv
// Short queue of classified words between the front and back ends.
module gti_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  gti_pkg::qword_t push_word,
    output logic            pop_valid,
    input  logic            pop_ready,
    output gti_pkg::qword_t pop_word
);
    import gti_pkg::*;

    qword_t     ent_reg [QDEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = fill_reg < 2'(QDEPTH);
    assign pop_valid = fill_reg != 2'd0;
    assign pop_word = ent_reg[rp_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wp_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 2'd1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

FILE: sv/gti_back.sv
// Back end: breakpoint and table storage, cell search, fractions and interpolation.
module gti_back #(
    parameter int SPEED_MAX   = 16,
    parameter int LOAD_MAX    = 16,
    parameter int SLOPE_MAX   = 8,
    parameter int TABLE_COUNT = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gti_pkg::cnt_t   cnt,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  gti_pkg::qword_t pop_word,
    gti_result_if.source    result
);
    import gti_pkg::*;

    localparam int SIW = $clog2(SPEED_MAX);
    localparam int LIW = $clog2(LOAD_MAX);
    localparam int PIW = $clog2(SLOPE_MAX);
    localparam int AW  = $clog2(TABLE_COUNT * 2048);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_AXLO = 5'd1;
    localparam logic [4:0] S_AXHI = 5'd2;
    localparam logic [4:0] S_SRCH = 5'd3;
    localparam logic [4:0] S_LOV  = 5'd4;
    localparam logic [4:0] S_HIV  = 5'd5;
    localparam logic [4:0] S_PREP = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_JOB  = 5'd8;
    localparam logic [4:0] S_ADR1 = 5'd9;
    localparam logic [4:0] S_ADR2 = 5'd10;
    localparam logic [4:0] S_RDA  = 5'd11;
    localparam logic [4:0] S_RDB  = 5'd12;
    localparam logic [4:0] S_WB   = 5'd13;
    localparam logic [4:0] S_MUL  = 5'd14;
    localparam logic [4:0] S_ADD  = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic signed [31:0] spd_br [SPEED_MAX];
    logic signed [31:0] lod_br [LOAD_MAX];
    logic signed [31:0] slp_br [SLOPE_MAX];
    logic signed [31:0] mem [TABLE_COUNT * 2048];
    logic signed [31:0] mem_q;

    logic [4:0]         state_reg, state_next;
    logic [1:0]         axis_reg, axis_next;
    logic [4:0]         i_reg, i_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] hi_reg, hi_next;
    logic [32:0]        d_reg, d_next;
    logic [32:0]        rem_reg, rem_next;
    logic [15:0]        q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [4:0]         idx_reg [3];
    logic [4:0]         idx_next [3];
    logic [16:0]        t_reg [3];
    logic [16:0]        t_next [3];
    logic signed [31:0] crd_reg [3];
    logic signed [31:0] crd_next [3];
    logic [1:0]         sel_reg, sel_next;
    logic [2:0]         j_reg, j_next;
    logic [10:0]        m1_reg, m1_next;
    logic [10:0]        base_reg, base_next;
    logic signed [31:0] la_reg, la_next;
    logic signed [31:0] lb_reg, lb_next;
    logic [16:0]        lt_reg, lt_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [31:0] c_reg [4];
    logic signed [31:0] c_next [4];
    logic signed [31:0] res_reg, res_next;
    logic               rvalid_reg, rvalid_next;

    logic [4:0]         br_addr;
    logic signed [31:0] br_val;
    logic [4:0]         n_cur;
    logic signed [31:0] crd_cur;
    logic               is3d;
    logic [2:0]         n_mem;
    logic [AW-1:0]      rd_addr;
    logic               ax_done;
    logic [16:0]        t_fin;
    logic signed [32:0] d33;
    logic signed [32:0] diff33;
    logic [33:0]        rem2;
    logic               qb;
    logic [4:0]         vv;
    logic [4:0]         gg;
    logic signed [32:0] ldiff;
    logic signed [34:0] lsum;
    logic               fin_job;
    logic [1:0]         dest;

    assign is3d = cnt.slp > 4'd1;
    assign n_mem = is3d ? 3'd4 : 3'd2;
    assign pop_ready = state_reg == S_IDLE;
    assign result.valid = rvalid_reg;
    assign result.interpolated = res_reg;

    // Breakpoint and table writes happen as their words leave the queue.
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            case (pop_word.kind)
                K_SPEED: spd_br[SIW'(pop_word.idx)] <= pop_word.value;
                K_LOAD:  lod_br[LIW'(pop_word.idx)] <= pop_word.value;
                K_SLOPE: slp_br[PIW'(pop_word.idx)] <= pop_word.value;
                K_TABLE: mem[AW'({pop_word.sel, pop_word.idx})] <= pop_word.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            S_AXHI:  br_addr = n_cur - 5'd1;
            S_SRCH:  br_addr = i_reg + 5'd1;
            S_LOV:   br_addr = i_reg;
            S_HIV:   br_addr = i_reg + 5'd1;
            default: br_addr = 5'd0;
        endcase
        case (axis_reg)
            2'd0:
            begin
                n_cur = cnt.spd;
                br_val = spd_br[SIW'(br_addr)];
                crd_cur = crd_reg[0];
            end
            2'd1:
            begin
                n_cur = cnt.lod;
                br_val = lod_br[LIW'(br_addr)];
                crd_cur = crd_reg[1];
            end
            default:
            begin
                n_cur = {1'b0, cnt.slp};
                br_val = slp_br[PIW'(br_addr)];
                crd_cur = crd_reg[2];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next = axis_reg;
        i_next = i_reg;
        x_next = x_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        t_next = t_reg;
        crd_next = crd_reg;
        sel_next = sel_reg;
        j_next = j_reg;
        m1_next = m1_reg;
        base_next = base_reg;
        la_next = la_reg;
        lb_next = lb_reg;
        lt_next = lt_reg;
        prod_next = prod_reg;
        c_next = c_reg;
        res_next = res_reg;
        rvalid_next = rvalid_reg;
        rd_addr = AW'({sel_reg, base_reg});
        ax_done = 1'b0;
        t_fin = 17'd0;
        d33 = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
        diff33 = {x_reg[31], x_reg} - {lo_reg[31], lo_reg};
        rem2 = {rem_reg, 1'b0};
        qb = rem2 >= {1'b0, d_reg};
        vv = idx_reg[0] + (is3d ? {4'd0, j_reg[1]} : {4'd0, j_reg[0]});
        gg = idx_reg[1] + (is3d ? {4'd0, j_reg[0]} : 5'd0);
        ldiff = {lb_reg[31], lb_reg} - {la_reg[31], la_reg};
        lsum = {{3{la_reg[31]}}, la_reg} + prod_reg[50:16];
        fin_job = is3d ? (j_reg == 3'd6) : (j_reg == 3'd2);
        dest = (is3d && j_reg >= 3'd4) ? {1'b0, j_reg == 3'd5} : j_reg[1:0];

        if (rvalid_reg && result.ready)
            rvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_word.kind == K_QUERY)
                    begin
                        sel_next = pop_word.sel;
                        crd_next[0] = pop_word.qv;
                        crd_next[1] = pop_word.qg;
                        crd_next[2] = pop_word.qs;
                        axis_next = 2'd0;
                        state_next = S_AXLO;
                    end
                    else if (pop_word.kind == K_ZERO)
                    begin
                        c_next[0] = 32'sd0;
                        state_next = S_DONE;
                    end
                end
            end
            S_AXLO:
            begin
                x_next = (crd_cur < br_val) ? br_val : crd_cur;
                state_next = S_AXHI;
            end
            S_AXHI:
            begin
                if (x_reg > br_val)
                    x_next = br_val;
                i_next = 5'd0;
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if ({1'b0, i_reg} + 6'd1 < {1'b0, n_cur} - 6'd1 && br_val < x_reg)
                    i_next = i_reg + 5'd1;
                else
                    state_next = S_LOV;
            end
            S_LOV:
            begin
                lo_next = br_val;
                state_next = S_HIV;
            end
            S_HIV:
            begin
                hi_next = br_val;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (hi_reg <= lo_reg || diff33 <= 33'sd0)
                begin
                    ax_done = 1'b1;
                    t_fin = 17'd0;
                end
                else if (diff33 >= d33)
                begin
                    ax_done = 1'b1;
                    t_fin = T_ONE;
                end
                else
                begin
                    rem_next = diff33;
                    d_next = d33;
                    q_next = 16'd0;
                    cnt_next = 5'd16;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One quotient bit a cycle; the remainder stays below the cell width.
                if (qb)
                    rem_next = 33'(rem2 - {1'b0, d_reg});
                else
                    rem_next = rem2[32:0];
                q_next = {q_reg[14:0], qb};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    ax_done = 1'b1;
                    t_fin = {1'b0, q_reg[14:0], qb};
                end
            end
            S_JOB:
            begin
                if (j_reg < n_mem)
                    state_next = S_ADR1;
                else
                begin
                    if (is3d && j_reg == 3'd5)
                    begin
                        la_next = c_reg[2];
                        lb_next = c_reg[3];
                    end
                    else
                    begin
                        la_next = c_reg[0];
                        lb_next = c_reg[1];
                    end
                    lt_next = fin_job ? t_reg[0] : t_reg[1];
                    state_next = S_MUL;
                end
            end
            S_ADR1:
            begin
                m1_next = 11'({6'd0, vv} * {6'd0, cnt.lod}) + {6'd0, gg};
                state_next = S_ADR2;
            end
            S_ADR2:
            begin
                if (is3d)
                    base_next = 11'(m1_reg * {7'd0, cnt.slp}) + {6'd0, idx_reg[2]};
                else
                    base_next = m1_reg;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                rd_addr = AW'({sel_reg, base_reg + 11'd1});
                la_next = mem_q;
                state_next = S_WB;
            end
            S_WB:
            begin
                lb_next = mem_q;
                lt_next = is3d ? t_reg[2] : t_reg[1];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = 51'(ldiff * $signed({1'b0, lt_reg})) + 51'sd32768;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                c_next[fin_job ? 2'd0 : dest] = lsum[31:0];
                if (fin_job)
                    state_next = S_DONE;
                else
                begin
                    j_next = j_reg + 3'd1;
                    state_next = S_JOB;
                end
            end
            S_DONE:
            begin
                if (!rvalid_reg || result.ready)
                begin
                    res_next = c_reg[0];
                    rvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (ax_done)
        begin
            t_next[axis_reg] = t_fin;
            idx_next[axis_reg] = i_reg;
            if (axis_reg == 2'd0 || (axis_reg == 2'd1 && is3d))
            begin
                axis_next = axis_reg + 2'd1;
                state_next = S_AXLO;
            end
            else
            begin
                j_next = 3'd0;
                state_next = S_JOB;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rvalid_reg <= 1'b0;
            axis_reg <= 2'd0;
            cnt_reg <= 5'd0;
            j_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            rvalid_reg <= rvalid_next;
            axis_reg <= axis_next;
            cnt_reg <= cnt_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        x_reg <= x_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        d_reg <= d_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        idx_reg <= idx_next;
        t_reg <= t_next;
        crd_reg <= crd_next;
        sel_reg <= sel_next;
        m1_reg <= m1_next;
        base_reg <= base_next;
        la_reg <= la_next;
        lb_reg <= lb_next;
        lt_reg <= lt_next;
        prod_reg <= prod_next;
        c_reg <= c_next;
        res_reg <= res_next;
    end

    // The search never looks past the last breakpoint of the axis.
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH |-> ({1'b0, i_reg} + 6'd1 < {1'b0, n_cur}))
        else $error("cell search ran past the axis end");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < d_reg)
        else $error("fraction divider remainder out of range");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rvalid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result word appeared outside the completion step");

    a_mem_job: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDA |-> j_reg < n_mem)
        else $error("table read issued for a reduction step");

endmodule

FILE: sv/grid_trilinear_interpolator.sv
// Top level of the grid trilinear interpolator.
//
//  channel  direction  fields
//  item     in         mode, table_select, entry_index, entry_value, query_*
//  result   out        interpolated
//  cfg      in         addr (register index), data
//
// A breakpoint or table word is written as it leaves the queue. A query searches two
// axes (three in 3D); each axis clamps the coordinate, searches the cell, reads both
// cell ends and checks them, then runs the fraction divider for 16 quotient bits if
// needed. Each table pair is then addressed, read and blended, then each reduction step.
// After reset all breakpoints and table words read as undefined until written.
// A two-word queue lets the input side keep taking words while a query runs,
// and a finished result waits in its own register while the next word starts.
module grid_trilinear_interpolator #(
    parameter int SPEED_MAX   = 16,
    parameter int LOAD_MAX    = 16,
    parameter int SLOPE_MAX   = 8,
    parameter int TABLE_COUNT = 4
) (
    input logic          clk,
    input logic          rst_n,
    gti_item_if.sink     item,
    gti_result_if.source result,
    gti_cfg_if.sink      cfg
);
    import gti_pkg::*;

    cnt_t   cnt;
    logic   push_valid;
    logic   push_ready;
    qword_t push_word;
    logic   pop_valid;
    logic   pop_ready;
    qword_t pop_word;

    gti_front #(
        .SPEED_MAX(SPEED_MAX), .LOAD_MAX(LOAD_MAX),
        .SLOPE_MAX(SLOPE_MAX), .TABLE_COUNT(TABLE_COUNT)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .item(item), .cfg(cfg), .cnt(cnt),
        .push_valid(push_valid), .push_ready(push_ready), .push_word(push_word)
    );

    gti_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(push_valid), .push_ready(push_ready), .push_word(push_word),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_word(pop_word)
    );

    gti_back #(
        .SPEED_MAX(SPEED_MAX), .LOAD_MAX(LOAD_MAX),
        .SLOPE_MAX(SLOPE_MAX), .TABLE_COUNT(TABLE_COUNT)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cnt(cnt),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_word(pop_word),
        .result(result)
    );

endmodule
